FILE: rtl/wbmls_pkg.sv
package wbmls_pkg;

  // Fixed field widths.
  localparam int unsigned ADDR_W  = 64;
  localparam int unsigned DATA_W  = 64;
  localparam int unsigned SIZE_W  = 4;
  localparam int unsigned WIN_W   = 13;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned LANE_W  = 3;   // byte lane inside a 64-bit word

  // Largest access in bytes.
  localparam logic [SIZE_W-1:0] MAX_SIZE = 4'd8;

  // Register defaults.
  localparam int unsigned       DEF_MEM_BYTES = 4096;
  localparam logic [WIN_W-1:0]  WIN_RESET     = 13'd4096;
  localparam logic [ADDR_W-1:0] BASE_RESET    = '0;

  // Depth of the queue between the classifier and the access engine.
  localparam int unsigned DEF_QUEUE_DEPTH = 2;

  // Configuration register indexes.
  typedef enum logic {
    REG_BASE_ADDRESS = 1'b0,
    REG_WINDOW_BYTES = 1'b1
  } cfg_reg_t;

  // Access kinds.
  typedef enum logic {
    ACT_LOAD  = 1'b0,
    ACT_STORE = 1'b1
  } action_t;

  // One classified access as it travels through the queue. The offset is
  // relative to the base; an accepted access always lies below the window,
  // which is at most 2**WIN_W - 1 bytes, so WIN_W bits carry it.
  typedef struct packed {
    action_t           action;
    logic [WIN_W-1:0]  offset;
    logic [SIZE_W-1:0] size;
    logic [DATA_W-1:0] write_data;
    logic              refused;
    logic              odd;
  } acc_entry_t;

  // Access engine states.
  typedef enum logic [1:0] {
    BK_IDLE   = 2'd0,
    BK_ACCESS = 2'd1,
    BK_DONE   = 2'd2
  } bk_state_t;

endpackage

FILE: rtl/wbmls_front.sv
module wbmls_front #(
  parameter int unsigned MEM_BYTES = wbmls_pkg::DEF_MEM_BYTES
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // Input word handshake.
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  wbmls_pkg::action_t            in_action,
  input  logic [wbmls_pkg::ADDR_W-1:0]  in_address,
  input  logic [wbmls_pkg::SIZE_W-1:0]  in_size,
  input  logic [wbmls_pkg::DATA_W-1:0]  in_write_data,
  // Configuration writes.
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  wbmls_pkg::cfg_reg_t           cfg_index,
  input  logic [wbmls_pkg::ADDR_W-1:0]  cfg_data,
  // Toward the queue.
  output logic                          q_push,
  output wbmls_pkg::acc_entry_t         q_entry,
  input  logic                          q_full
);

  localparam int unsigned WIN_W   = wbmls_pkg::WIN_W;
  localparam int unsigned WIN_MAX = (1 << WIN_W) - 1;
  localparam int unsigned MEM_CAP = (MEM_BYTES < WIN_MAX) ? MEM_BYTES : WIN_MAX;
  localparam logic [WIN_W-1:0] MEM_CAP_W = WIN_W'(MEM_CAP);

  logic [wbmls_pkg::ADDR_W-1:0] base_r;
  logic [WIN_W-1:0]             window_r;
  logic [WIN_W-1:0]             live_win;
  logic [wbmls_pkg::ADDR_W:0]   diff;
  logic                         below_base;
  logic                         far_off;
  logic [WIN_W:0]               end_pos;
  logic                         too_big;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r   <= wbmls_pkg::BASE_RESET;
      window_r <= wbmls_pkg::WIN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        wbmls_pkg::REG_BASE_ADDRESS: base_r   <= cfg_data;
        wbmls_pkg::REG_WINDOW_BYTES: window_r <= cfg_data[WIN_W-1:0];
        default: ;
      endcase
    end
  end

  // The window never reaches past the end of the store.
  assign live_win = (window_r > MEM_CAP_W) ? MEM_CAP_W : window_r;

  // One subtract gives both the borrow (below the base) and the offset.
  assign diff       = {1'b0, in_address} - {1'b0, base_r};
  assign below_base = diff[wbmls_pkg::ADDR_W];
  assign far_off    = |diff[wbmls_pkg::ADDR_W-1:WIN_W];
  assign end_pos    = {1'b0, diff[WIN_W-1:0]} + (WIN_W+1)'(in_size);
  assign too_big    = in_size > wbmls_pkg::MAX_SIZE;

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

  always_comb begin
    q_entry            = '0;
    q_entry.action     = in_action;
    q_entry.offset     = diff[WIN_W-1:0];
    q_entry.size       = in_size;
    q_entry.write_data = in_write_data;
    q_entry.refused    = too_big || below_base || far_off || (end_pos > {1'b0, live_win});
    q_entry.odd        = in_size[0];
  end

endmodule

FILE: rtl/wbmls_queue.sv
module wbmls_queue #(
  parameter int unsigned DEPTH = wbmls_pkg::DEF_QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  wbmls_pkg::acc_entry_t push_entry,
  output logic                  full,
  input  logic                  pop,
  output wbmls_pkg::acc_entry_t pop_entry,
  output logic                  not_empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  wbmls_pkg::acc_entry_t slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push;
  logic             do_pop;

  assign full      = (count_r == FULL_CNT);
  assign not_empty = (count_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_entry = slots[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr_r] <= push_entry;
    end
  end

  // The fill count never runs past the number of slots.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("queue count exceeds depth");

endmodule

FILE: rtl/wbmls_back.sv
module wbmls_back #(
  parameter int unsigned MEM_BYTES = wbmls_pkg::DEF_MEM_BYTES
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // From the queue.
  input  logic                          q_not_empty,
  input  wbmls_pkg::acc_entry_t         q_entry,
  output logic                          q_pop,
  // Result word handshake.
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [wbmls_pkg::DATA_W-1:0]  out_read_data,
  output logic                          out_range_error,
  output logic                          out_odd_size_warning
);

  localparam int unsigned AW     = (MEM_BYTES > 1) ? $clog2(MEM_BYTES) : 1;
  localparam int unsigned OFS_W  = wbmls_pkg::WIN_W;
  localparam int unsigned SUM_W  = (AW > OFS_W) ? AW : OFS_W;
  localparam int unsigned LANE_W = wbmls_pkg::LANE_W;
  localparam int unsigned BYTE_W = wbmls_pkg::BYTE_W;
  localparam int unsigned DATA_W = wbmls_pkg::DATA_W;

  logic [BYTE_W-1:0] mem [MEM_BYTES];
  logic [BYTE_W-1:0] mem_q_r;

  wbmls_pkg::bk_state_t  state_r, state_nxt;
  wbmls_pkg::acc_entry_t cur_r, cur_nxt;
  logic [LANE_W-1:0]     idx_r, idx_nxt;
  logic [DATA_W-1:0]     asm_r, asm_nxt;
  logic                  rd_pend_r, rd_pend_nxt;
  logic [LANE_W-1:0]     rd_pos_r, rd_pos_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0]     out_data_r, out_data_nxt;
  logic                  out_err_r, out_err_nxt;
  logic                  out_odd_r, out_odd_nxt;

  logic [SUM_W-1:0]  addr_sum;
  logic [AW-1:0]     mem_addr;
  logic              mem_we;
  logic              mem_re;
  logic [DATA_W-1:0] load_word;
  logic              out_free;
  logic              last_byte;

  assign addr_sum  = SUM_W'(cur_r.offset) + SUM_W'(idx_r);
  assign mem_addr  = addr_sum[AW-1:0];
  assign out_free  = !out_valid_r || out_tready;
  assign last_byte = ({1'b0, idx_r} == (cur_r.size - 1'b1));

  // The byte read in the previous cycle is merged into its lane here.
  assign load_word = rd_pend_r ?
                     (asm_r | (DATA_W'(mem_q_r) << {rd_pos_r, 3'b000})) : asm_r;

  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    idx_nxt       = idx_r;
    asm_nxt       = load_word;
    rd_pend_nxt   = 1'b0;
    rd_pos_nxt    = idx_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_err_nxt   = out_err_r;
    out_odd_nxt   = out_odd_r;
    q_pop         = 1'b0;
    mem_we        = 1'b0;
    mem_re        = 1'b0;

    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      wbmls_pkg::BK_IDLE: begin
        if (q_not_empty) begin
          q_pop   = 1'b1;
          cur_nxt = q_entry;
          idx_nxt = '0;
          asm_nxt = '0;
          if (!q_entry.refused && (q_entry.size != '0)) begin
            state_nxt = wbmls_pkg::BK_ACCESS;
          end else begin
            state_nxt = wbmls_pkg::BK_DONE;
          end
        end
      end
      wbmls_pkg::BK_ACCESS: begin
        if (cur_r.action == wbmls_pkg::ACT_STORE) begin
          mem_we = 1'b1;
        end else begin
          mem_re      = 1'b1;
          rd_pend_nxt = 1'b1;
        end
        idx_nxt = idx_r + 1'b1;
        if (last_byte) begin
          state_nxt = wbmls_pkg::BK_DONE;
        end
      end
      wbmls_pkg::BK_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = load_word;
          out_err_nxt   = cur_r.refused;
          out_odd_nxt   = cur_r.odd;
          state_nxt     = wbmls_pkg::BK_IDLE;
        end
      end
      default: begin
        state_nxt = wbmls_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= wbmls_pkg::BK_IDLE;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    idx_r      <= idx_nxt;
    asm_r      <= asm_nxt;
    rd_pos_r   <= rd_pos_nxt;
    out_data_r <= out_data_nxt;
    out_err_r  <= out_err_nxt;
    out_odd_r  <= out_odd_nxt;
  end

  // Byte store: one write or one registered read per cycle.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= cur_r.write_data[{idx_r, 3'b000} +: BYTE_W];
    end
    if (mem_re) begin
      mem_q_r <= mem[mem_addr];
    end
  end

  assign out_tvalid           = out_valid_r;
  assign out_read_data        = out_data_r;
  assign out_range_error      = out_err_r;
  assign out_odd_size_warning = out_odd_r;

  // A refused access never reaches the byte store.
  a_no_refused_access: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == wbmls_pkg::BK_ACCESS) |-> !cur_r.refused)
    else $error("refused access entered the byte loop");

  // A read byte is only ever pending right after a load step.
  a_read_follows_load: assert property (@(posedge clk) disable iff (!rst_n)
    rd_pend_r |-> ($past(state_r) == wbmls_pkg::BK_ACCESS) &&
                  ($past(cur_r.action) == wbmls_pkg::ACT_LOAD))
    else $error("pending read without a load step");

  // Stores and refused accesses always return a zero word.
  a_zero_for_store: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == wbmls_pkg::BK_DONE) && out_free &&
     ((cur_r.action == wbmls_pkg::ACT_STORE) || cur_r.refused))
    |=> (out_read_data == '0))
    else $error("nonzero read data for a store or refused access");

endmodule

FILE: rtl/windowed_byte_memory_load_store.sv
// Channel | Direction | Handshake            | Payload
// in_     | input     | in_tvalid/in_tready  | tuser: action; tdata: address, size, write_data
// out_    | output    | out_tvalid/out_tready| tuser: range_error, odd_size_warning; tdata: read_data
// cfg_    | input     | cfg_valid/cfg_ready  | cfg_index register, cfg_data value
//
// A load or store of n bytes (1 to 8) inside the window goes through these steps in the access
// engine: take the word from the queue, one byte per step on the byte-wide store port, and
// then load the output register. A refused or zero-size access skips the byte steps.
// Words are classified on arrival; a queue, by default two deep, lets them keep coming.
// Reset clears control state and the two window registers; the byte store is not cleared.
// The result register holds a word until it is taken, and the engine waits in its last step.
module windowed_byte_memory_load_store #(
  parameter int unsigned MEM_BYTES   = wbmls_pkg::DEF_MEM_BYTES,
  parameter int unsigned QUEUE_DEPTH = wbmls_pkg::DEF_QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst_n,
  // Input words.
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [135:0] in_tdata,   // [63:0] address, [67:64] size,
                                   // [131:68] write_data, [135:132] zero
  input  logic [0:0]   in_tuser,   // [0] action (0 load, 1 store)
  // Result words.
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [63:0]  out_tdata,  // [63:0] read_data
  output logic [1:0]   out_tuser,  // [0] range_error, [1] odd_size_warning
  // Configuration writes.
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [0:0]   cfg_index,
  input  logic [63:0]  cfg_data
);

  wbmls_pkg::acc_entry_t push_entry;
  wbmls_pkg::acc_entry_t pop_entry;
  logic                  q_push;
  logic                  q_full;
  logic                  q_pop;
  logic                  q_not_empty;
  wbmls_pkg::action_t    in_action;
  wbmls_pkg::cfg_reg_t   cfg_reg;
  logic                  range_error;
  logic                  odd_warn;

  assign in_action = wbmls_pkg::action_t'(in_tuser[0]);
  assign cfg_reg   = wbmls_pkg::cfg_reg_t'(cfg_index[0]);

  // The classifier checks each word against the window as it is accepted.
  wbmls_front #(
    .MEM_BYTES (MEM_BYTES)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_action     (in_action),
    .in_address    (in_tdata[63:0]),
    .in_size       (in_tdata[67:64]),
    .in_write_data (in_tdata[131:68]),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_reg),
    .cfg_data      (cfg_data),
    .q_push        (q_push),
    .q_entry       (push_entry),
    .q_full        (q_full)
  );

  // Classified accesses wait here for the access engine.
  wbmls_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .pop_entry  (pop_entry),
    .not_empty  (q_not_empty)
  );

  // The access engine walks the bytes of each access and owns the byte store.
  wbmls_back #(
    .MEM_BYTES (MEM_BYTES)
  ) u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .q_not_empty          (q_not_empty),
    .q_entry              (pop_entry),
    .q_pop                (q_pop),
    .out_tvalid           (out_tvalid),
    .out_tready           (out_tready),
    .out_read_data        (out_tdata),
    .out_range_error      (range_error),
    .out_odd_size_warning (odd_warn)
  );

  assign out_tuser = {odd_warn, range_error};

endmodule
